// File: src/window_taper_stream_defines.svh
// ----------------------------------------------------------------------------
// window_taper_stream_defines.svh
// Assertion macros used by the window taper stream top level.
// ----------------------------------------------------------------------------
`ifndef WINDOW_TAPER_STREAM_DEFINES_SVH
`define WINDOW_TAPER_STREAM_DEFINES_SVH

// Same-cycle implication, checked on the block clock outside of reset.
`define WTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the block clock outside of reset.
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared constants, control types and the cosine table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wts_pkg;

   // Sizes of the data path.
   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_ROW        = 4096;
   localparam int PHASE_STEPS    = 4096;
   localparam int PHASE_BITS     = $clog2(PHASE_STEPS);
   localparam int QUO_BITS       = PHASE_BITS + 1;
   localparam int DIV_STEPS      = QUO_BITS;
   localparam int COS_ENTRIES    = PHASE_STEPS / 2 + 1;
   localparam int ROM_ADDR_BITS  = $clog2(COS_ENTRIES);
   localparam int POS_BITS       = 12;
   localparam int ROW_BITS       = 13;
   localparam int BORDER_BITS    = 12;
   localparam int KIND_BITS      = 2;
   localparam int COEF_BITS      = 16;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_KIND   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BORDER_MODE   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BORDER_LENGTH = 2'd3;

   // Window kinds; the unused code behaves as the unit window.
   localparam logic [KIND_BITS-1:0] KIND_UNIT    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_HANN    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_HAMMING = 2'd2;

   // Reset values of the registers.
   localparam logic [KIND_BITS-1:0]   RESET_WINDOW_KIND   = KIND_HANN;
   localparam logic [ROW_BITS-1:0]    RESET_ROW_LENGTH    = 13'd4096;
   localparam logic                   RESET_BORDER_MODE   = 1'b0;
   localparam logic [BORDER_BITS-1:0] RESET_BORDER_LENGTH = 12'd0;

   // Q1.15 window constants.
   localparam int HANN_FULL  = 32767;
   localparam int HAMMING_A  = 17695;
   localparam int HAMMING_B  = 15073;
   localparam int PROD_SHIFT = 15;

   // Q30 angle constants for building the cosine table.
   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
   localparam longint unsigned TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                  64'd90, 64'd132, 64'd182, 64'd240};

   // Commands from the controller to the data path.
   typedef struct packed {
      logic load;
      logic div_step;
      logic rom_read;
      logic scale;
      logic coef;
      logic product;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the data path to the controller.
   typedef struct packed {
      logic bypass;
   } ctrl_status_type;

   typedef logic signed [15:0] cos_rom_type [COS_ENTRIES];

   // Q1.15 cosine of a phase in the first half turn, by integer Taylor series.
   function automatic logic signed [15:0] cos_q15(input longint unsigned p);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned mag;
      longint          sum;
      logic            neg;
      neg = 1'b0;
      x = (p * TWO_PI_Q30 + PHASE_STEPS / 2) / PHASE_STEPS;
      if (x > PI_Q30) begin
         x = PI_Q30;
      end
      if (x > HALF_PI_Q30) begin
         x = PI_Q30 - x;
         neg = 1'b1;
      end
      x2 = (x * x) >> 30;
      sum = longint'(ONE_Q30);
      term = ONE_Q30;
      for (int k = 0; k < 8; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k[0] == 1'b0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
         sum = longint'(ONE_Q30);
      end
      mag = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      return neg ? -16'(mag) : 16'(mag);
   endfunction

   // Cosine table over the first half turn, built at elaboration.
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      for (int i = 0; i < COS_ENTRIES; i++) begin
         rom[i] = cos_q15(longint'(i));
      end
      return rom;
   endfunction

endpackage

// File: src/wts_req_if.sv
// ----------------------------------------------------------------------------
// wts_req_if
// Sample input channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wts_req_if #(
   parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// File: src/wts_rsp_if.sv
// ----------------------------------------------------------------------------
// wts_rsp_if
// Windowed sample output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wts_rsp_if #(
   parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          border_error;
   logic                          row_end;

   modport source (output valid, output sample_out, output border_error,
                   output row_end, input ready);
   modport sink   (input valid, input sample_out, input border_error,
                   input row_end, output ready);
endinterface

// File: src/wts_controller.sv
// ----------------------------------------------------------------------------
// wts_controller
// Sequencer that steps one sample through divide, lookup and multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wts_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  wts_pkg::ctrl_status_type status,
   output wts_pkg::ctrl_cmd_type    cmd
);

   localparam int CNT_BITS = $clog2(wts_pkg::DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_SCALE,
      ST_COEF,
      ST_PRODUCT,
      ST_DONE
   } state_type;

   state_type           state_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                rsp_valid_ff;
   logic                slot_free;

   // The output register can take a result when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Command decode from the current state.
   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.rom_read = (state_ff == ST_LOOKUP);
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.coef     = (state_ff == ST_COEF);
      cmd.product  = (state_ff == ST_PRODUCT);
      cmd.out_load = (state_ff == ST_DONE) && slot_free;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State, divide step counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               count_ff <= '0;
               if (req_valid) begin
                  state_ff <= status.bypass ? ST_DONE : ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (count_ff == CNT_BITS'(wts_pkg::DIV_STEPS - 1)) begin
                  count_ff <= '0;
                  state_ff <= ST_LOOKUP;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_LOOKUP:  state_ff <= ST_SCALE;
            ST_SCALE:   state_ff <= ST_COEF;
            ST_COEF:    state_ff <= ST_PRODUCT;
            ST_PRODUCT: state_ff <= ST_DONE;
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: src/wts_datapath.sv
// ----------------------------------------------------------------------------
// wts_datapath
// Registers, row position, phase divider, cosine table and multipliers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wts_datapath #(
   parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [wts_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wts_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]         sample_in,
   input  wts_pkg::ctrl_cmd_type                 cmd,
   output wts_pkg::ctrl_status_type              status,
   output logic signed [SAMPLE_BITS-1:0]         sample_out,
   output logic                                  border_error,
   output logic                                  row_end
);

   localparam int PB = wts_pkg::PHASE_BITS;
   localparam int QB = wts_pkg::QUO_BITS;
   localparam int RB = wts_pkg::ROW_BITS;
   localparam int AB = wts_pkg::ROM_ADDR_BITS;
   localparam int CB = wts_pkg::COEF_BITS;
   localparam int PRODUCT_BITS = SAMPLE_BITS + CB + 1;
   localparam wts_pkg::cos_rom_type COS_ROM = wts_pkg::build_cos_rom();

   // Configuration registers and row position.
   logic [wts_pkg::KIND_BITS-1:0]   window_kind_ff;
   logic [RB-1:0]                   row_length_ff;
   logic                            border_mode_ff;
   logic [wts_pkg::BORDER_BITS-1:0] border_length_ff;
   logic [wts_pkg::POS_BITS-1:0]    row_position_ff;
   logic [wts_pkg::POS_BITS-1:0]    row_position_in;

   // Per-transaction registers.
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          bypass_ff;
   logic                          error_ff;
   logic                          last_ff;
   logic                          hann_ff;
   logic                          zero_len_ff;
   logic [PB-1:0]                 divisor_ff;
   logic [PB-1:0]                 rem_ff;
   logic                          shift_bit_ff;
   logic [QB-1:0]                 quo_ff;
   logic signed [15:0]            cos_ff;
   logic signed [31:0]            hamm_prod_ff;
   logic [CB-1:0]                 coef_ff;
   logic signed [PRODUCT_BITS-1:0] product_ff;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff;
   logic                          border_error_ff;
   logic                          row_end_ff;

   // Decode signals for the transaction being accepted.
   logic [RB-1:0] len_eff;
   logic [RB-1:0] len_last;
   logic          is_last;
   logic [RB-1:0] pos_eff;
   logic [RB-1:0] border_x2;
   logic [RB-1:0] tail_start;
   logic          border_err;
   logic          in_head;
   logic          in_tail;
   logic          win_kind;
   logic [RB-1:0] win_index;
   logic [RB-1:0] win_len;
   logic [RB-1:0] win_div;

   // Divider, lookup and coefficient signals.
   logic [QB-1:0]     div_shifted;
   logic              div_ge;
   logic [QB-1:0]     div_diff;
   logic [QB-1:0]     phase;
   logic [PB-1:0]     phase_mod;
   logic [PB:0]       phase_mirror;
   logic [AB-1:0]     rom_addr;
   logic signed [31:0] hamm_prod_in;
   logic signed [17:0] hann_sum;
   logic signed [17:0] hamm_coef;
   logic [CB-1:0]     coef_in;
   logic signed [PRODUCT_BITS-1:0] product_in;
   logic signed [SAMPLE_BITS-1:0]  sample_out_in;

   // Clamp the row length and find the effective position in the row.
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = RB'(1);
      end else if (row_length_ff > RB'(wts_pkg::MAX_ROW)) begin
         len_eff = RB'(wts_pkg::MAX_ROW);
      end else begin
         len_eff = row_length_ff;
      end
      len_last = len_eff - 1'b1;
      is_last  = {1'b0, row_position_ff} >= len_last;
      pos_eff  = is_last ? len_last : {1'b0, row_position_ff};
      row_position_in = is_last ? '0 : row_position_ff + 1'b1;
   end

   // Select the window region, its index and its length.
   always_comb begin
      border_x2  = {border_length_ff, 1'b0};
      tail_start = len_eff - {1'b0, border_length_ff};
      border_err = border_mode_ff && (border_x2 > len_eff);
      in_head    = pos_eff < {1'b0, border_length_ff};
      in_tail    = pos_eff >= tail_start;
      win_kind   = (window_kind_ff == wts_pkg::KIND_HANN) ||
                   (window_kind_ff == wts_pkg::KIND_HAMMING);
      if (!border_mode_ff) begin
         win_index = pos_eff;
         win_len   = len_eff;
      end else if (in_head) begin
         win_index = pos_eff;
         win_len   = border_x2;
      end else begin
         win_index = pos_eff + border_x2 - len_eff;
         win_len   = border_x2;
      end
      win_div = win_len - 1'b1;
      status.bypass = !win_kind || border_err ||
                      (border_mode_ff && !in_head && !in_tail);
   end

   // One restoring divide step: quotient bit of index*PHASE_STEPS/(len-1).
   always_comb begin
      div_shifted = {rem_ff, shift_bit_ff};
      div_ge      = div_shifted >= {1'b0, divisor_ff};
      div_diff    = div_shifted - {1'b0, divisor_ff};
   end

   // Fold the phase onto the first half turn for the table address.
   always_comb begin
      phase        = zero_len_ff ? '0 : quo_ff;
      phase_mod    = phase[PB-1:0];
      phase_mirror = (PB+1)'(wts_pkg::PHASE_STEPS) - {1'b0, phase_mod};
      if ({1'b0, phase_mod} > (PB+1)'(wts_pkg::PHASE_STEPS / 2)) begin
         rom_addr = phase_mirror[AB-1:0];
      end else begin
         rom_addr = phase_mod[AB-1:0];
      end
   end

   // Coefficient arithmetic and the final product.
   always_comb begin
      hamm_prod_in = 32'(cos_ff) * 32'sd15073;
      hann_sum     = 18'(wts_pkg::HANN_FULL) - 18'(cos_ff);
      hamm_coef    = 18'(wts_pkg::HAMMING_A) - 18'(hamm_prod_ff >>> wts_pkg::PROD_SHIFT);
      coef_in      = hann_ff ? hann_sum[CB:1] : hamm_coef[CB-1:0];
      product_in   = sample_ff * $signed({1'b0, coef_ff});
      if (!bypass_ff) begin
         sample_out_in = product_ff[SAMPLE_BITS+wts_pkg::PROD_SHIFT-1:wts_pkg::PROD_SHIFT];
      end else if (error_ff) begin
         sample_out_in = '0;
      end else begin
         sample_out_in = sample_ff;
      end
   end

   // Configuration writes and row position.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_kind_ff   <= wts_pkg::RESET_WINDOW_KIND;
         row_length_ff    <= wts_pkg::RESET_ROW_LENGTH;
         border_mode_ff   <= wts_pkg::RESET_BORDER_MODE;
         border_length_ff <= wts_pkg::RESET_BORDER_LENGTH;
         row_position_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               wts_pkg::REG_WINDOW_KIND:
                  window_kind_ff <= csr_wdata[wts_pkg::KIND_BITS-1:0];
               wts_pkg::REG_ROW_LENGTH:
                  row_length_ff <= csr_wdata[RB-1:0];
               wts_pkg::REG_BORDER_MODE:
                  border_mode_ff <= csr_wdata[0];
               wts_pkg::REG_BORDER_LENGTH:
                  border_length_ff <= csr_wdata[wts_pkg::BORDER_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            row_position_ff <= row_position_in;
         end
      end
   end

   // Transaction capture, divider, table read and multiplier stages.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff    <= sample_in;
         bypass_ff    <= status.bypass;
         error_ff     <= border_err;
         last_ff      <= is_last;
         hann_ff      <= (window_kind_ff == wts_pkg::KIND_HANN);
         zero_len_ff  <= (win_len <= RB'(1));
         divisor_ff   <= win_div[PB-1:0];
         rem_ff       <= {1'b0, win_index[PB-1:1]};
         shift_bit_ff <= win_index[0];
         quo_ff       <= '0;
      end
      if (cmd.div_step) begin
         rem_ff       <= div_ge ? div_diff[PB-1:0] : div_shifted[PB-1:0];
         shift_bit_ff <= 1'b0;
         quo_ff       <= {quo_ff[QB-2:0], div_ge};
      end
      if (cmd.rom_read) begin
         cos_ff <= COS_ROM[rom_addr];
      end
      if (cmd.scale) begin
         hamm_prod_ff <= hamm_prod_in;
      end
      if (cmd.coef) begin
         coef_ff <= coef_in;
      end
      if (cmd.product) begin
         product_ff <= product_in;
      end
      if (cmd.out_load) begin
         sample_out_ff   <= sample_out_in;
         border_error_ff <= error_ff;
         row_end_ff      <= last_ff;
      end
   end

   assign sample_out   = sample_out_ff;
   assign border_error = border_error_ff;
   assign row_end      = row_end_ff;

endmodule

// File: src/window_taper_stream.sv
// ----------------------------------------------------------------------------
// window_taper_stream
// Streams signed samples through a Hann, Hamming or unit window.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on req_chan and leave on rsp_chan, one result per sample,
//   each moved by a valid/ready transaction. Registers are written through the
//   csr_ port while no transaction is in flight; writes do not move the row
//   position.
//   A windowed sample passes through the divide, lookup, scale, coefficient
//   and product steps before its result is loaded into the output register;
//   the block takes the next sample only once that result is loaded. The
//   phase divider retires one quotient bit per cycle. Samples that pass
//   unchanged or are zeroed by a border error go straight to the final step.
//   Reset clears the row position, loads the register defaults (Hann window,
//   rows of 4096, full mode) and empties the output register.
//   When the receiver stalls, the finished result holds in the output
//   register; the next sample is still accepted and worked on, and waits
//   only at its final step for the output register to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_taper_stream_defines.svh"

module window_taper_stream #(
   parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   wts_req_if.sink                            req_chan,
   wts_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [wts_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wts_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   wts_pkg::ctrl_cmd_type    cmd;
   wts_pkg::ctrl_status_type status;

   // Sequencer.
   wts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   wts_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sample_in    (req_chan.sample_in),
      .cmd          (cmd),
      .status       (status),
      .sample_out   (rsp_chan.sample_out),
      .border_error (rsp_chan.border_error),
      .row_end      (rsp_chan.row_end)
   );

   // A result may only be loaded when the output register is free.
   `WTS_ASSERT_NOW(a_out_load_free, cmd.out_load, !rsp_chan.valid || rsp_chan.ready, "result loaded over a pending transaction")

   // A flagged border error always carries a zero sample.
   `WTS_ASSERT_NOW(a_error_zero, rsp_chan.valid && rsp_chan.border_error, rsp_chan.sample_out == '0, "border error with nonzero sample")

   // After a transaction is accepted, the block is busy in the cycle after it.
   `WTS_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready, "ready held after acceptance")

   // A new sample is never captured in the cycle a divide step runs or a result is loaded.
   `WTS_ASSERT_NOW(a_cmd_exclusive, cmd.load, !cmd.div_step && !cmd.out_load, "overlapping data path commands")

endmodule

// File: tb/tb_window_taper_stream.sv
// ----------------------------------------------------------------------------
// tb_window_taper_stream
// Self-checking testbench for the window taper stream.
//
// Samples are queued by the stimulus process and sent in bursts by a clocked
// driver. Every accepted sample is run through a local predictor of the Hann,
// Hamming and unit windows, in full-row and border modes. A clocked monitor
// stalls on its own pattern and checks each result against the oldest
// prediction. Registers change only while nothing is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_taper_stream;
   import wts_pkg::*;

   localparam int RANDOM_ITEMS = 1730;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES = 200;
   localparam int MAX_REPORTS = 10;

   // Q30 angle constants of the cosine predictor.
   localparam longint unsigned TURN = 64'd4096;
   localparam longint unsigned ANGLE_ONE = 64'd1073741824;
   localparam longint unsigned ANGLE_PI = 64'd3373259426;
   localparam longint unsigned ANGLE_HALF_PI = 64'd1686629713;
   localparam longint unsigned ANGLE_TWO_PI = 64'd6746518852;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          border_error;
      logic                          row_end;
   } taper_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   wts_req_if req_if ();
   wts_rsp_if rsp_if ();

   window_taper_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and the row position.
   logic [KIND_BITS-1:0]   cfg_kind = RESET_WINDOW_KIND;
   logic [ROW_BITS-1:0]    cfg_row_length = RESET_ROW_LENGTH;
   logic                   cfg_border_mode = RESET_BORDER_MODE;
   logic [BORDER_BITS-1:0] cfg_border_length = RESET_BORDER_LENGTH;
   longint unsigned        row_pos = 0;

   logic signed [SAMPLE_BITS-1:0] pending_samples[$];
   taper_result_t                 expected_taper[$];

   int gap_left = 0;
   int burst_left = 8;
   int samples_queued = 0;
   int samples_accepted = 0;
   int results_checked = 0;
   int mismatches = 0;
   int settings_used = 0;
   int row_ends_seen = 0;
   int border_errors_seen = 0;
   int holds_done = 0;
   int hold_left = 0;
   int stall_tick = 0;
   int stall_mode = 0;
   logic next_valid;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready = 1'b0;
   end

   // Q1.15 cosine of a phase step: Q30 angle, integer Taylor series, and
   // rounding of the magnitude half up.
   function automatic longint taper_cosine(input longint unsigned phase);
      longint unsigned p;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned mag;
      longint          sum;
      bit              neg;
      neg = 1'b0;
      p = phase % TURN;
      if (2 * p > TURN) begin
         p = TURN - p;
      end
      x = (p * ANGLE_TWO_PI + TURN / 2) / TURN;
      if (x > ANGLE_PI) begin
         x = ANGLE_PI;
      end
      if (x > ANGLE_HALF_PI) begin
         x = ANGLE_PI - x;
         neg = 1'b1;
      end
      x2 = (x * x) >> 30;
      sum = longint'(ANGLE_ONE);
      term = ANGLE_ONE;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(ANGLE_ONE)) begin
         sum = longint'(ANGLE_ONE);
      end
      mag = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // One sample times the window coefficient at index k of a window of len.
   function automatic longint taper_window(input longint s, input longint unsigned k,
                                           input longint unsigned len);
      longint unsigned phase;
      longint          c;
      longint          coef;
      if (cfg_kind != KIND_HANN && cfg_kind != KIND_HAMMING) begin
         return s;
      end
      phase = (len > 1) ? (k * TURN) / (len - 1) : 0;
      c = taper_cosine(phase);
      if (cfg_kind == KIND_HANN) begin
         coef = (HANN_FULL - c) >>> 1;
      end else begin
         coef = HAMMING_A - ((HAMMING_B * c) >>> PROD_SHIFT);
      end
      return (s * coef) >>> PROD_SHIFT;
   endfunction

   // Expected result of one sample; advances the row position.
   function automatic taper_result_t predict_taper(input logic signed [SAMPLE_BITS-1:0] sample);
      longint unsigned len;
      longint unsigned pos;
      longint unsigned b;
      longint          s;
      longint          y;
      taper_result_t   r;
      len = cfg_row_length;
      if (len == 0) begin
         len = 1;
      end
      if (len > MAX_ROW) begin
         len = MAX_ROW;
      end
      pos = row_pos;
      b = cfg_border_length;
      r.row_end = 1'b0;
      r.border_error = 1'b0;
      if (pos >= len - 1) begin
         pos = len - 1;
         r.row_end = 1'b1;
      end
      s = sample;
      if (!cfg_border_mode) begin
         y = taper_window(s, pos, len);
      end else if (2 * b > len) begin
         r.border_error = 1'b1;
         y = 0;
      end else if (pos < b) begin
         y = taper_window(s, pos, 2 * b);
      end else if (pos >= len - b) begin
         y = taper_window(s, b + (pos - (len - b)), 2 * b);
      end else begin
         y = s;
      end
      row_pos = r.row_end ? 0 : pos + 1;
      r.sample_out = y[SAMPLE_BITS-1:0];
      return r;
   endfunction

   // Driver: offers queued samples in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample_in <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_taper.push_back(predict_taper(req_if.sample_in));
            samples_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_samples.size() > 0) begin
               next_valid = 1'b1;
               req_if.sample_in <= pending_samples.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_if.valid <= next_valid;
         end
      end
   end

   // Monitor: checks each result transaction and sets the receiver stalls.
   always @(posedge clock) begin
      taper_result_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (rsp_if.row_end) begin
               row_ends_seen++;
            end
            if (rsp_if.border_error) begin
               border_errors_seen++;
            end
            if (expected_taper.size() == 0) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("Unexpected result: sample %0d border_error %0b row_end %0b",
                           rsp_if.sample_out, rsp_if.border_error, rsp_if.row_end);
               end
               mismatches++;
            end else begin
               want = expected_taper.pop_front();
               if (rsp_if.sample_out !== want.sample_out ||
                   rsp_if.border_error !== want.border_error ||
                   rsp_if.row_end !== want.row_end) begin
                  if (mismatches < MAX_REPORTS) begin
                     $display("Mismatch at result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              results_checked, want.sample_out, want.border_error,
                              want.row_end, rsp_if.sample_out, rsp_if.border_error,
                              rsp_if.row_end);
                  end
                  mismatches++;
               end
            end
            // Long hold-offs so that the block fills up and stalls its input.
            if (results_checked == 500 || results_checked == 1200) begin
               hold_left = HOLD_CYCLES;
               holds_done++;
            end
         end
         // Stall pattern, with a character that is chosen at random.
         stall_tick++;
         if (stall_tick % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (stall_tick % 3 != 0);
            endcase
         end
      end
   end

   // One register write; the predictor copy follows it.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         REG_WINDOW_KIND:   cfg_kind = value[KIND_BITS-1:0];
         REG_ROW_LENGTH:    cfg_row_length = value[ROW_BITS-1:0];
         REG_BORDER_MODE:   cfg_border_mode = value[0];
         REG_BORDER_LENGTH: cfg_border_length = value[BORDER_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] kind_data,
                            input logic [CSR_DATA_BITS-1:0] row_data,
                            input logic [CSR_DATA_BITS-1:0] mode_data,
                            input logic [CSR_DATA_BITS-1:0] border_data);
      write_reg(REG_WINDOW_KIND, kind_data);
      write_reg(REG_ROW_LENGTH, row_data);
      write_reg(REG_BORDER_MODE, mode_data);
      write_reg(REG_BORDER_LENGTH, border_data);
      settings_used++;
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] value);
      pending_samples.push_back(value);
      samples_queued++;
   endtask

   // Waits until every sample has gone out and every result has come back.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_samples.size() > 0 || req_if.valid || expected_taper.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 11))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return ($urandom_range(0, 1) == 0) ? 16'sh0000 : 16'shFFFF;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Stimulus: directed settings first, then random register settings.
   initial begin
      int unsigned row;
      int unsigned eff_row;
      int unsigned border;
      int unsigned count;
      logic [CSR_DATA_BITS-1:0] kind_data;
      logic [CSR_DATA_BITS-1:0] mode_data;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: Hann over a full row of 4096, sample extremes.
      queue_sample(16'sh8000);
      queue_sample(16'sh7FFF);
      queue_sample(16'sh0000);
      queue_sample(16'shFFFF);
      queue_sample(16'sh0001);
      queue_sample(16'sh5555);
      wait_idle();

      // Row of one, lowered while mid-row: Hamming at its single point.
      configure(KIND_HAMMING, 13'd1, 13'd0, 13'd0);
      queue_sample(16'sh7FFF);
      queue_sample(16'sh8000);
      queue_sample(16'sh1234);
      wait_idle();

      // Unused window code with stray upper bits, and row length zero.
      configure(13'h1FFF, 13'd0, 13'd0, 13'd0);
      queue_sample(16'sh8000);
      queue_sample(16'sh7FFF);
      wait_idle();

      // Unit window with a row length above the maximum.
      configure(KIND_UNIT, 13'd8191, 13'd0, 13'd0);
      queue_sample(16'sh8000);
      queue_sample(16'sh7FFF);
      wait_idle();

      // Border mode with a border too large for the row.
      configure(KIND_HANN, 13'd5, 13'd1, 13'd3);
      queue_sample(16'sh7FFF);
      queue_sample(16'sh8000);
      queue_sample(16'sh2AAA);
      wait_idle();

      // Border mode with a border of zero passes every sample.
      configure(KIND_HAMMING, 13'd9, 13'd1, 13'd0);
      queue_sample(16'sh8000);
      queue_sample(16'sh7FFF);
      wait_idle();

      // Border exactly half the row: every sample is tapered.
      configure(KIND_HANN, 13'd4, 13'd1, 13'd2);
      queue_sample(16'sh8000);
      queue_sample(16'sh7FFF);
      queue_sample(16'sh8000);
      queue_sample(16'sh7FFF);
      wait_idle();

      // Random register settings, mostly short rows so that rows end often.
      while (samples_queued < RANDOM_ITEMS + 22) begin
         kind_data = CSR_DATA_BITS'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) begin
            kind_data[CSR_DATA_BITS-1:KIND_BITS] = (CSR_DATA_BITS-KIND_BITS)'($urandom);
         end
         case ($urandom_range(0, 9))
            0: row = 0;
            1: row = $urandom_range(1, 4);
            2, 3, 4: row = $urandom_range(5, 64);
            5, 6: row = $urandom_range(65, 700);
            7: row = MAX_ROW;
            8: row = $urandom_range(MAX_ROW + 1, 8191);
            default: row = $urandom_range(1, MAX_ROW);
         endcase
         eff_row = (row == 0) ? 1 : ((row > MAX_ROW) ? MAX_ROW : row);
         case ($urandom_range(0, 7))
            0: border = 0;
            1: border = eff_row / 2;
            2: border = eff_row / 2 + 1;
            3: border = 2048;
            4: border = $urandom_range(0, 4095);
            default: border = $urandom_range(0, eff_row / 2);
         endcase
         mode_data = CSR_DATA_BITS'($urandom);
         mode_data[0] = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 3) == 0) begin
            border = border | 32'h1000;
         end
         configure(kind_data, CSR_DATA_BITS'(row), mode_data, CSR_DATA_BITS'(border));
         count = $urandom_range(20, 100);
         repeat (count) queue_sample(random_sample());
         wait_idle();
      end

      repeat (40) @(posedge clock);
      $display("Covered %0d samples over %0d register settings with %0d receiver hold-offs.",
               samples_accepted, settings_used, holds_done);
      $display("Results checked: %0d, with %0d row ends and %0d border errors.",
               results_checked, row_ends_seen, border_errors_seen);
      if (mismatches == 0 && expected_taper.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding.", expected_taper.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
